// ===== rtl/lbfr_pkg.sv =====
// ----------------------------------------------------------------------------
// lbfr_pkg
// Shared types and constants of the LED bar fill ramp: field widths, register
// indexes and reset values, configuration and divider structs.
// ----------------------------------------------------------------------------
package lbfr_pkg;

   localparam int MAX_UNITS  = 1024;

   localparam int FUNC_W     = 2;
   localparam int FRAC_W     = 16;
   localparam int FRAC_SHIFT = 15;     // Q1.15, full = 65536 / 2
   localparam int POS_W      = 18;
   localparam int STEP_W     = 16;
   localparam int UNIT_W     = 11;
   localparam int HUE_W      = 16;
   localparam int MB_W       = 8;
   localparam int LED_W      = 20;
   localparam int WUNIT_W    = POS_W + 1;   // unit index plus one guard step

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int DIV_N_W    = 28;
   localparam int DIV_D_W    = 11;
   localparam int DIV_CNT_W  = $clog2(DIV_N_W);

   localparam int MUL_A_W    = WUNIT_W;
   localparam int MUL_B_W    = 17;
   localparam int PROD_W     = MUL_A_W + MUL_B_W;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK       = 2'd0,
      FUNC_SET_TARGET = 2'd1,
      FUNC_CLEAR      = 2'd2
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STEP_SIZE    = 3'd0,
      REG_LEDS_PER_SEG = 3'd1,
      REG_UNIT_COUNT   = 3'd2,
      REG_START_HUE    = 3'd3,
      REG_END_HUE      = 3'd4,
      REG_MAX_BRIGHT   = 3'd5,
      REG_CLIP_LOWER   = 3'd6,
      REG_CLIP_UPPER   = 3'd7
   } csr_reg_type;

   localparam logic [STEP_W-1:0] RST_STEP_SIZE    = 16'd10;
   localparam logic [UNIT_W-1:0] RST_LEDS_PER_SEG = 11'd0;
   localparam logic [UNIT_W-1:0] RST_UNIT_COUNT   = 11'd64;
   localparam logic [HUE_W-1:0]  RST_START_HUE    = 16'd32768;
   localparam logic [HUE_W-1:0]  RST_END_HUE      = 16'd32768;
   localparam logic [MB_W-1:0]   RST_MAX_BRIGHT   = 8'd255;
   localparam logic [UNIT_W-1:0] RST_CLIP_LOWER   = 11'd0;
   localparam logic [UNIT_W-1:0] RST_CLIP_UPPER   = 11'd0;

   // effective values: max_bright never zero, unit_count capped at MAX_UNITS
   typedef struct packed {
      logic [STEP_W-1:0] step_size;
      logic [UNIT_W-1:0] leds_per_seg;
      logic [UNIT_W-1:0] unit_count;
      logic [HUE_W-1:0]  start_hue;
      logic [HUE_W-1:0]  end_hue;
      logic [MB_W-1:0]   max_bright;
      logic [UNIT_W-1:0] clip_lower;
      logic [UNIT_W-1:0] clip_upper;
   } cfg_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
      logic [DIV_D_W-1:0] remainder;
   } div_rsp_type;

endpackage

// ===== rtl/lbfr_if.sv =====
// ----------------------------------------------------------------------------
// lbfr_if
// Valid/ready channels of the LED bar fill ramp: request and result.
// ----------------------------------------------------------------------------
interface lbfr_req_if import lbfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [FRAC_W-1:0] target_fraction;

   modport source (output valid, func, target_fraction, input ready);
   modport sink   (input valid, func, target_fraction, output ready);
endinterface

interface lbfr_rsp_if import lbfr_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              clear_all;
   logic [LED_W-1:0]  first_led;
   logic [UNIT_W-1:0] led_count;
   logic [HUE_W-1:0]  hue;
   logic [MB_W-1:0]   level;
   logic              last;

   modport source (output valid, clear_all, first_led, led_count, hue, level, last,
                   input ready);
   modport sink   (input valid, clear_all, first_led, led_count, hue, level, last,
                   output ready);
endinterface

// ===== rtl/lbfr_csr.sv =====
// ----------------------------------------------------------------------------
// lbfr_csr
// Configuration registers with write decode; presents effective values.
// ----------------------------------------------------------------------------
module lbfr_csr import lbfr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [UNIT_W-1:0] lps_ff, lps_in;
   logic [UNIT_W-1:0] units_ff, units_in;
   logic [HUE_W-1:0]  shue_ff, shue_in;
   logic [HUE_W-1:0]  ehue_ff, ehue_in;
   logic [MB_W-1:0]   mb_ff, mb_in;
   logic [UNIT_W-1:0] clo_ff, clo_in;
   logic [UNIT_W-1:0] cup_ff, cup_in;

   always_comb begin
      step_in  = step_ff;
      lps_in   = lps_ff;
      units_in = units_ff;
      shue_in  = shue_ff;
      ehue_in  = ehue_ff;
      mb_in    = mb_ff;
      clo_in   = clo_ff;
      cup_in   = cup_ff;
      if (csr_wr_en) begin
         unique case (csr_reg_type'(csr_index))
            REG_STEP_SIZE:    step_in  = csr_wdata[STEP_W-1:0];
            REG_LEDS_PER_SEG: lps_in   = csr_wdata[UNIT_W-1:0];
            REG_UNIT_COUNT:   units_in = csr_wdata[UNIT_W-1:0];
            REG_START_HUE:    shue_in  = csr_wdata[HUE_W-1:0];
            REG_END_HUE:      ehue_in  = csr_wdata[HUE_W-1:0];
            REG_MAX_BRIGHT:   mb_in    = csr_wdata[MB_W-1:0];
            REG_CLIP_LOWER:   clo_in   = csr_wdata[UNIT_W-1:0];
            REG_CLIP_UPPER:   cup_in   = csr_wdata[UNIT_W-1:0];
            default:          step_in  = step_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= RST_STEP_SIZE;
         lps_ff   <= RST_LEDS_PER_SEG;
         units_ff <= RST_UNIT_COUNT;
         shue_ff  <= RST_START_HUE;
         ehue_ff  <= RST_END_HUE;
         mb_ff    <= RST_MAX_BRIGHT;
         clo_ff   <= RST_CLIP_LOWER;
         cup_ff   <= RST_CLIP_UPPER;
      end else begin
         step_ff  <= step_in;
         lps_ff   <= lps_in;
         units_ff <= units_in;
         shue_ff  <= shue_in;
         ehue_ff  <= ehue_in;
         mb_ff    <= mb_in;
         clo_ff   <= clo_in;
         cup_ff   <= cup_in;
      end
   end

   always_comb begin
      cfg.step_size    = step_ff;
      cfg.leds_per_seg = lps_ff;
      cfg.unit_count   = (units_ff > UNIT_W'(MAX_UNITS)) ? UNIT_W'(MAX_UNITS) : units_ff;
      cfg.start_hue    = shue_ff;
      cfg.end_hue      = ehue_ff;
      cfg.max_bright   = (mb_ff == '0) ? MB_W'(1) : mb_ff;
      cfg.clip_lower   = clo_ff;
      cfg.clip_upper   = cup_ff;
   end

endmodule

// ===== rtl/lbfr_div.sv =====
// ----------------------------------------------------------------------------
// lbfr_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// Done pulses for one cycle once the last quotient bit is registered.
// ----------------------------------------------------------------------------
module lbfr_div import lbfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_N_W-1:0]   quo_ff, quo_in;
   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   dsr_ff, dsr_in;

   logic [DIV_D_W:0]     shifted;
   logic [DIV_D_W:0]     sub;
   logic                 fits;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_N_W-1]};
      fits    = shifted >= {1'b0, dsr_ff};
      sub     = shifted - {1'b0, dsr_ff};
   end

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      done_in = busy_ff && (cnt_ff == '0);
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(DIV_N_W - 1);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_N_W-2:0], fits};
         rem_in = fits ? sub[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule

// ===== rtl/led_bar_fill_ramp_top.sv =====
// ----------------------------------------------------------------------------
// led_bar_fill_ramp_top
// Ramps an LED bar graph toward a target fill level, one request at a time.
//
// Requests come in on req_bus (valid/ready): tick, set target or clear. Each
// tick moves the current position by step_size toward the target and sends
// up to two LED writes on rsp_bus (valid/ready), the last one flagged.
// Clear sends one clear_all result. The user writes configuration on the csr_
// port only while the block is idle; the block does not enforce this.
// req_bus.ready is high only while the sequencer is idle. A request passes:
//   set target: S_MP, S_TMUL, S_TSET; clear: S_CLR;
//   tick: S_MP, S_STEP, then the divide and emit states. Each division by
//   max_brightness and each interpolated hue runs through one shared
//   bit-serial divider; ticks need one or two unit divisions plus a hue
//   division per result where the hue lies inside the clip range.
// Results leave through an output register; the next request is taken while
// the last result still waits there. A stalled receiver holds the sequencer
// only when a further result is due. Synchronous reset clears the positions,
// loads register reset values and empties the output register.
// ----------------------------------------------------------------------------
module led_bar_fill_ramp_top import lbfr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lbfr_req_if.sink              req_bus,
   lbfr_rsp_if.source            rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   typedef enum logic [13:0] {
      S_IDLE  = 14'b00_0000_0000_0001,
      S_MP    = 14'b00_0000_0000_0010,
      S_TMUL  = 14'b00_0000_0000_0100,
      S_TSET  = 14'b00_0000_0000_1000,
      S_STEP  = 14'b00_0000_0001_0000,
      S_DIV_U = 14'b00_0000_0010_0000,
      S_DIV_T = 14'b00_0000_0100_0000,
      S_MAIN  = 14'b00_0000_1000_0000,
      S_HUE   = 14'b00_0001_0000_0000,
      S_HMUL  = 14'b00_0010_0000_0000,
      S_HDIV  = 14'b00_0100_0000_0000,
      S_FL    = 14'b00_1000_0000_0000,
      S_EMIT  = 14'b01_0000_0000_0000,
      S_CLR   = 14'b10_0000_0000_0000
   } state_type;

   cfg_type     cfg;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type          state_ff, state_in;
   logic [FUNC_W-1:0]  func_ff, func_in;
   logic [FRAC_W-1:0]  frac_ff, frac_in;
   logic [POS_W-1:0]   cur_ff, cur_in;
   logic [POS_W-1:0]   tgt_ff, tgt_in;
   logic [POS_W-1:0]   mp_ff, mp_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [WUNIT_W-1:0] w_ff, w_in;
   logic [MB_W-1:0]    elvl_ff, elvl_in;
   logic               elast_ff, elast_in;
   logic               guard_ff, guard_in;
   logic [HUE_W-1:0]   hue_ff, hue_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_clear_ff, rsp_clear_in;
   logic [LED_W-1:0]   rsp_first_ff, rsp_first_in;
   logic [UNIT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [HUE_W-1:0]   rsp_hue_ff, rsp_hue_in;
   logic [MB_W-1:0]    rsp_level_ff, rsp_level_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;

   logic               rising, falling, out_free, lps_zero, hue_up;
   logic [POS_W:0]     sum_up;
   logic signed [POS_W+1:0] dif_dn;
   logic [POS_W-1:0]   step_mp;
   logic [POS_W-1:0]   cur_step;
   logic [POS_W:0]     tset_val;
   logic signed [UNIT_W+1:0] hi_s, lo_s, span_s;
   logic signed [WUNIT_W:0]  w_s, hi_ext;
   logic               w_below, w_above, w_equal;
   logic [HUE_W-1:0]   hue_mag;
   logic [UNIT_W-1:0]  w_off;
   logic [HUE_W-1:0]   q_hue;

   lbfr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lbfr_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // position step and hue range helpers
   always_comb begin
      rising   = tgt_ff > cur_ff;
      falling  = tgt_ff < cur_ff;
      out_free = !rsp_valid_ff || rsp_bus.ready;
      lps_zero = (cfg.leds_per_seg == '0);
      step_mp  = prod_ff[POS_W-1:0];

      sum_up = {1'b0, cur_ff} + (POS_W+1)'(cfg.step_size);
      dif_dn = $signed({2'b00, cur_ff}) - $signed((POS_W+2)'(cfg.step_size));
      if (rising) begin
         cur_step = (sum_up > {1'b0, tgt_ff}) ? tgt_ff : sum_up[POS_W-1:0];
      end else if (dif_dn < $signed({2'b00, tgt_ff})) begin
         cur_step = tgt_ff;
      end else if (dif_dn > $signed({2'b00, step_mp})) begin
         cur_step = step_mp;
      end else begin
         cur_step = dif_dn[POS_W-1:0];
      end

      tset_val = prod_ff[FRAC_SHIFT +: POS_W+1];

      hi_s    = $signed({2'b00, cfg.unit_count}) - $signed({2'b00, cfg.clip_upper});
      lo_s    = $signed({2'b00, cfg.clip_lower});
      span_s  = hi_s - lo_s;
      w_s     = $signed({1'b0, w_ff});
      hi_ext  = (WUNIT_W+1)'(hi_s);
      w_below = w_ff < WUNIT_W'(cfg.clip_lower);
      w_above = w_s > hi_ext;
      w_equal = (hi_s == lo_s);
      w_off   = w_ff[UNIT_W-1:0] - cfg.clip_lower;
      hue_up  = cfg.end_hue >= cfg.start_hue;
      hue_mag = hue_up ? (cfg.end_hue - cfg.start_hue) : (cfg.start_hue - cfg.end_hue);
      q_hue   = div_rsp.quotient[HUE_W-1:0];
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MP: begin
            mul_a = MUL_A_W'(cfg.max_bright);
            mul_b = MUL_B_W'(cfg.unit_count);
         end
         S_TMUL: begin
            mul_a = MUL_A_W'(prod_ff[POS_W-1:0]);
            mul_b = MUL_B_W'(frac_ff);
         end
         S_HUE: begin
            mul_a = MUL_A_W'(w_off);
            mul_b = MUL_B_W'(hue_mag);
         end
         S_FL, S_EMIT: begin
            mul_a = w_ff;
            mul_b = MUL_B_W'(cfg.leds_per_seg);
         end
         default: mul_a = '0;
      endcase
      prod_in = mul_a * mul_b;
   end

   assign req_bus.ready = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      frac_in      = frac_ff;
      cur_in       = cur_ff;
      tgt_in       = tgt_ff;
      mp_in        = mp_ff;
      w_in         = w_ff;
      elvl_in      = elvl_ff;
      elast_in     = elast_ff;
      guard_in     = guard_ff;
      hue_in       = hue_ff;
      div_req      = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_clear_in = rsp_clear_ff;
      rsp_first_in = rsp_first_ff;
      rsp_count_in = rsp_count_ff;
      rsp_hue_in   = rsp_hue_ff;
      rsp_level_in = rsp_level_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               func_in = req_bus.func;
               frac_in = req_bus.target_fraction;
               unique case (req_bus.func) inside
                  FUNC_TICK, FUNC_SET_TARGET: state_in = S_MP;
                  FUNC_CLEAR: begin
                     cur_in   = '0;
                     tgt_in   = '0;
                     state_in = S_CLR;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_MP: begin
            state_in = (func_ff == FUNC_SET_TARGET) ? S_TMUL : S_STEP;
         end
         S_TMUL: begin
            mp_in    = prod_ff[POS_W-1:0];
            state_in = S_TSET;
         end
         S_TSET: begin
            tgt_in   = (tset_val > {1'b0, mp_ff}) ? mp_ff : tset_val[POS_W-1:0];
            state_in = S_IDLE;
         end
         S_STEP: begin
            if (!rising && !falling) begin
               state_in = S_IDLE;
            end else begin
               cur_in           = cur_step;
               div_req.start    = 1'b1;
               div_req.dividend = DIV_N_W'(cur_step);
               div_req.divisor  = DIV_D_W'(cfg.max_bright);
               state_in         = S_DIV_U;
            end
         end
         S_DIV_U: begin
            if (div_rsp.done) begin
               w_in    = div_rsp.quotient[WUNIT_W-1:0];
               elvl_in = div_rsp.remainder[MB_W-1:0];
               if (lps_zero) begin
                  state_in = S_MAIN;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = DIV_N_W'(tgt_ff);
                  div_req.divisor  = DIV_D_W'(cfg.max_bright);
                  state_in         = S_DIV_T;
               end
            end
         end
         S_DIV_T: begin
            if (div_rsp.done) begin
               // segment already holds the target: snap and stay silent
               if (div_rsp.quotient == DIV_N_W'(w_ff)) begin
                  tgt_in   = cur_ff;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_MAIN;
               end
            end
         end
         S_MAIN: begin
            guard_in = (rising && w_ff != '0) ||
                       (falling && w_ff != WUNIT_W'(cfg.unit_count));
            elast_in = !((rising && w_ff != '0) ||
                         (falling && w_ff != WUNIT_W'(cfg.unit_count)));
            state_in = S_HUE;
         end
         S_HUE: begin
            if (w_below) begin
               hue_in   = cfg.start_hue;
               state_in = S_FL;
            end else if (w_above) begin
               hue_in   = cfg.end_hue;
               state_in = S_FL;
            end else if (w_equal) begin
               hue_in   = cfg.start_hue;
               state_in = S_FL;
            end else begin
               state_in = S_HMUL;
            end
         end
         S_HMUL: begin
            div_req.start    = 1'b1;
            div_req.dividend = prod_ff[DIV_N_W-1:0];
            div_req.divisor  = span_s[DIV_D_W-1:0];
            state_in         = S_HDIV;
         end
         S_HDIV: begin
            if (div_rsp.done) begin
               hue_in   = hue_up ? (cfg.start_hue + q_hue) : (cfg.start_hue - q_hue);
               state_in = S_FL;
            end
         end
         S_FL: begin
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_clear_in = 1'b0;
               rsp_first_in = lps_zero ? LED_W'(w_ff) : prod_ff[LED_W-1:0];
               rsp_count_in = lps_zero ? UNIT_W'(1) : cfg.leds_per_seg;
               rsp_hue_in   = hue_ff;
               rsp_level_in = elvl_ff;
               rsp_last_in  = elast_ff;
               if (guard_ff) begin
                  // neighbor guard: unit below full, or unit above off
                  guard_in = 1'b0;
                  elast_in = 1'b1;
                  w_in     = rising ? (w_ff - 1'b1) : (w_ff + 1'b1);
                  elvl_in  = rising ? cfg.max_bright : '0;
                  state_in = S_HUE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_CLR: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_clear_in = 1'b1;
               rsp_first_in = '0;
               rsp_count_in = '0;
               rsp_hue_in   = '0;
               rsp_level_in = '0;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         tgt_ff       <= '0;
         guard_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         tgt_ff       <= tgt_in;
         guard_ff     <= guard_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      frac_ff      <= frac_in;
      mp_ff        <= mp_in;
      prod_ff      <= prod_in;
      w_ff         <= w_in;
      elvl_ff      <= elvl_in;
      elast_ff     <= elast_in;
      hue_ff       <= hue_in;
      rsp_clear_ff <= rsp_clear_in;
      rsp_first_ff <= rsp_first_in;
      rsp_count_ff <= rsp_count_in;
      rsp_hue_ff   <= rsp_hue_in;
      rsp_level_ff <= rsp_level_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.clear_all = rsp_clear_ff;
   assign rsp_bus.first_led = rsp_first_ff;
   assign rsp_bus.led_count = rsp_count_ff;
   assign rsp_bus.hue       = rsp_hue_ff;
   assign rsp_bus.level     = rsp_level_ff;
   assign rsp_bus.last      = rsp_last_ff;

`ifndef SYNTHESIS
   a_div_done_awaited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == S_DIV_U || state_ff == S_DIV_T || state_ff == S_HDIV))
      else $error("divider finished outside a divide wait state");

   a_clear_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.clear_all) |->
         (rsp_bus.last && rsp_bus.first_led == '0 && rsp_bus.level == '0))
      else $error("clear result carries write data or is not last");

   a_clear_positions: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready && req_bus.func == FUNC_CLEAR) |=>
         (cur_ff == '0 && tgt_ff == '0))
      else $error("positions not zero after clear request");
`endif

endmodule

// ===== tb/sv/lbfr_ramp_checker.sv =====
// ----------------------------------------------------------------------------
// lbfr_ramp_checker
// Watches the request, result and CSR ports of the LED bar fill ramp, keeps
// its own copy of the registers and of the current and target positions,
// predicts the LED writes each accepted request causes and compares every
// accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module lbfr_ramp_checker import lbfr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   lbfr_req_if                   req_bus,
   lbfr_rsp_if                   rsp_bus,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint FULL_FRACTION = longint'(1) << FRAC_SHIFT;
   localparam longint POS_LIMIT     = (longint'(1) << POS_W) - 1;

   typedef struct {
      logic              clear_all;
      logic [LED_W-1:0]  first_led;
      logic [UNIT_W-1:0] led_count;
      logic [HUE_W-1:0]  hue;
      logic [MB_W-1:0]   level;
      logic              last;
   } led_write_t;

   cfg_type          cfg;          // raw register contents
   logic [POS_W-1:0] cur_pos;
   logic [POS_W-1:0] tgt_pos;
   led_write_t       led_write_q[$];
   int               failures = 0;

   function automatic longint eff_bright();
      return (cfg.max_bright == '0) ? longint'(1) : longint'(cfg.max_bright);
   endfunction

   function automatic longint eff_units();
      return (cfg.unit_count > MAX_UNITS) ? longint'(MAX_UNITS) : longint'(cfg.unit_count);
   endfunction

   function automatic logic [HUE_W-1:0] unit_hue(longint u);
      longint lo = longint'(cfg.clip_lower);
      longint hi = eff_units() - longint'(cfg.clip_upper);
      longint sh = longint'(cfg.start_hue);
      longint eh = longint'(cfg.end_hue);
      longint h;
      if (u < lo) h = sh;
      else if (u > hi) h = eh;
      else if (hi == lo) h = sh;
      else h = (u - lo) * (eh - sh) / (hi - lo) + sh;   // truncates toward zero
      return h[HUE_W-1:0];
   endfunction

   function automatic void push_write(longint u, longint level);
      led_write_t w;
      longint first;
      first = (cfg.leds_per_seg != '0) ? u * longint'(cfg.leds_per_seg) : u;
      w.clear_all = 1'b0;
      w.first_led = first[LED_W-1:0];
      w.led_count = (cfg.leds_per_seg != '0) ? cfg.leds_per_seg : UNIT_W'(1);
      w.hue       = unit_hue(u);
      w.level     = level[MB_W-1:0];
      w.last      = 1'b0;
      led_write_q.push_back(w);
   endfunction

   function automatic void advance_ramp(logic [FUNC_W-1:0] code, logic [FRAC_W-1:0] frac);
      longint mb;
      longint maxpos;
      longint cur;
      longint tgt;
      longint next;
      longint u;
      int     queued_before;
      mb     = eff_bright();
      maxpos = mb * eff_units();
      if (maxpos > POS_LIMIT) maxpos = POS_LIMIT;
      cur = longint'(cur_pos);
      tgt = longint'(tgt_pos);
      queued_before = led_write_q.size();
      case (code)
         FUNC_SET_TARGET: begin
            next = maxpos * longint'(frac) / FULL_FRACTION;
            tgt_pos = (next > maxpos) ? maxpos[POS_W-1:0] : next[POS_W-1:0];
         end
         FUNC_CLEAR: begin
            cur_pos = '0;
            tgt_pos = '0;
            led_write_q.push_back('{clear_all: 1'b1, first_led: '0, led_count: '0,
                                    hue: '0, level: '0, last: 1'b1});
         end
         FUNC_TICK: begin
            if (tgt != cur) begin
               if (tgt > cur) begin
                  next = cur + longint'(cfg.step_size);
                  if (next > tgt) next = tgt;
               end else begin
                  // clamp to target first, then to the top of the bar
                  next = cur - longint'(cfg.step_size);
                  if (next < tgt) next = tgt;
                  else if (next > maxpos) next = maxpos;
               end
               cur = next;
               u   = cur / mb;
               // segmented: reaching the target's segment snaps the target
               if (cfg.leds_per_seg != '0 && u == tgt / mb) tgt = cur;
               else push_write(u, cur % mb);
               if (tgt > cur && u != 0) push_write(u - 1, mb);
               else if (tgt < cur && u != maxpos / mb) push_write(u + 1, 0);
               cur_pos = cur[POS_W-1:0];
               tgt_pos = tgt[POS_W-1:0];
            end
         end
         default: ;   // unused code, ignored
      endcase
      if (led_write_q.size() > queued_before) led_write_q[$].last = 1'b1;
   endfunction

   function automatic void report(string field, logic [LED_W-1:0] want, logic [LED_W-1:0] got);
      $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      failures++;
   endfunction

   always @(posedge clock) begin
      led_write_t exp_w;
      if (reset) begin
         cfg = '{step_size: RST_STEP_SIZE, leds_per_seg: RST_LEDS_PER_SEG,
                 unit_count: RST_UNIT_COUNT, start_hue: RST_START_HUE,
                 end_hue: RST_END_HUE, max_bright: RST_MAX_BRIGHT,
                 clip_lower: RST_CLIP_LOWER, clip_upper: RST_CLIP_UPPER};
         cur_pos = '0;
         tgt_pos = '0;
         led_write_q.delete();
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (led_write_q.size() == 0) begin
               $display("%0t ns: unexpected result, expected none, actual first_led %0d level %0d",
                        $time, rsp_bus.first_led, rsp_bus.level);
               failures++;
            end else begin
               exp_w = led_write_q.pop_front();
               if (rsp_bus.clear_all !== exp_w.clear_all)
                  report("clear_all", exp_w.clear_all, rsp_bus.clear_all);
               if (rsp_bus.first_led !== exp_w.first_led)
                  report("first_led", exp_w.first_led, rsp_bus.first_led);
               if (rsp_bus.led_count !== exp_w.led_count)
                  report("led_count", exp_w.led_count, rsp_bus.led_count);
               if (rsp_bus.hue !== exp_w.hue)
                  report("hue", exp_w.hue, rsp_bus.hue);
               if (rsp_bus.level !== exp_w.level)
                  report("level", exp_w.level, rsp_bus.level);
               if (rsp_bus.last !== exp_w.last)
                  report("last", exp_w.last, rsp_bus.last);
            end
         end
         if (csr_wr_en) begin
            case (csr_reg_type'(csr_index))
               REG_STEP_SIZE:    cfg.step_size    = csr_wdata[STEP_W-1:0];
               REG_LEDS_PER_SEG: cfg.leds_per_seg = csr_wdata[UNIT_W-1:0];
               REG_UNIT_COUNT:   cfg.unit_count   = csr_wdata[UNIT_W-1:0];
               REG_START_HUE:    cfg.start_hue    = csr_wdata[HUE_W-1:0];
               REG_END_HUE:      cfg.end_hue      = csr_wdata[HUE_W-1:0];
               REG_MAX_BRIGHT:   cfg.max_bright   = csr_wdata[MB_W-1:0];
               REG_CLIP_LOWER:   cfg.clip_lower   = csr_wdata[UNIT_W-1:0];
               REG_CLIP_UPPER:   cfg.clip_upper   = csr_wdata[UNIT_W-1:0];
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            advance_ramp(req_bus.func, req_bus.target_fraction);
      end
      pending    <= led_write_q.size();
      fail_count <= failures;
   end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench of the LED bar fill ramp. Drives ticks, set-target, clear and
// unused requests under a sequence of register settings, first a directed
// set of ramps and corner settings, then randomized phases with random
// sender gaps, receiver stalls and long receiver hold-offs. Checking is
// done by lbfr_ramp_checker; this module only makes stimulus and reports.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lbfr_pkg::*;

   localparam int CLK_PERIOD    = 4;
   localparam int RESET_CYCLES  = 11;
   localparam int RANDOM_ITEMS  = 550;
   localparam int SETTLE_CYCLES = 160;      // longest tick plus margin
   localparam int HOLD_CYCLES   = 400;
   localparam int MAX_WAIT      = 14;
   localparam int TIMEOUT_NS    = 2_000_000;
   localparam int FULL_FRACTION = 1 << FRAC_SHIFT;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_ALWAYS} idle_mode_t;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    fail_count;
   int                    pending;

   idle_mode_t            req_gap_mode   = IDLE_SOME;
   idle_mode_t            rsp_stall_mode = IDLE_SOME;
   int                    holds_asked    = 0;
   int                    sent_items     = 0;

   lbfr_req_if req_bus ();
   lbfr_rsp_if rsp_bus ();

   led_bar_fill_ramp_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lbfr_ramp_checker i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .rsp_bus    (rsp_bus),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic int draw_wait(idle_mode_t mode);
      case (mode)
         IDLE_NONE: return 0;
         IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_WAIT) : 0;
         default:   return $urandom_range(0, MAX_WAIT);
      endcase
   endfunction

   function automatic cfg_type random_config();
      cfg_type c;
      int      pick;
      longint  mb_eff;
      longint  units_eff;
      longint  step;
      pick = $urandom_range(0, 9);
      c.max_bright = (pick == 0 || pick == 8) ? 8'd255 : (pick == 1) ? 8'd1 :
                     (pick == 2) ? 8'd0 : 8'($urandom_range(2, 40));
      c.unit_count = (pick == 3 || pick == 8) ? 11'd1024 :
                     (pick == 4) ? 11'($urandom_range(1025, 2047)) :
                     (pick == 5) ? 11'd1 : 11'($urandom_range(2, 48));
      c.leds_per_seg = ($urandom_range(0, 1) == 0) ? 11'd0 :
                       ($urandom_range(0, 5) == 0) ? 11'd1024 : 11'($urandom_range(1, 64));
      c.start_hue  = 16'($urandom);
      c.end_hue    = ($urandom_range(0, 4) == 0) ? c.start_hue : 16'($urandom);
      c.clip_lower = ($urandom_range(0, 7) == 0) ? 11'd1024 : 11'($urandom_range(0, 8));
      c.clip_upper = ($urandom_range(0, 7) == 0) ? 11'd1024 : 11'($urandom_range(0, 8));
      mb_eff    = (c.max_bright == 0) ? 1 : longint'(c.max_bright);
      units_eff = (c.unit_count > MAX_UNITS) ? MAX_UNITS : longint'(c.unit_count);
      // size the step so that a ramp takes a handful of ticks
      step = mb_eff * units_eff / $urandom_range(3, 15) + 1;
      if (pick == 6 || step > 65535) step = 65535;
      if (pick == 7) step = 1;
      c.step_size = step[STEP_W-1:0];
      return c;
   endfunction

   task automatic send_request(input logic [FUNC_W-1:0] code, input logic [FRAC_W-1:0] frac);
      int gap;
      gap = draw_wait(req_gap_mode);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.func            <= code;
      req_bus.target_fraction <= frac;
      do @(posedge clock); while (!req_bus.ready);
      if (code != FUNC_UNUSED) sent_items++;
   endtask

   // drop valid, wait for every predicted result, then let a silent tick finish
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   // junk above each register's width must be dropped by the block
   task automatic load_config(input cfg_type c);
      write_csr(REG_STEP_SIZE,    c.step_size);
      write_csr(REG_LEDS_PER_SEG, {5'($urandom), c.leds_per_seg});
      write_csr(REG_UNIT_COUNT,   {5'($urandom), c.unit_count});
      write_csr(REG_START_HUE,    c.start_hue);
      write_csr(REG_END_HUE,      c.end_hue);
      write_csr(REG_MAX_BRIGHT,   {8'($urandom), c.max_bright});
      write_csr(REG_CLIP_LOWER,   {5'($urandom), c.clip_lower});
      write_csr(REG_CLIP_UPPER,   {5'($urandom), c.clip_upper});
      csr_wr_en <= 1'b0;
   endtask

   // receiver: per-result stalls plus an occasional long hold-off
   initial begin
      int stall_left;
      int hold_left;
      int holds_served;
      stall_left    = 0;
      hold_left     = 0;
      holds_served  = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_served != holds_asked) begin
            holds_served = holds_asked;
            hold_left    = HOLD_CYCLES;
            stall_left   = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= (hold_left == 0);
         end else if (rsp_bus.valid && rsp_bus.ready) begin
            stall_left = draw_wait(rsp_stall_mode);
            rsp_bus.ready <= (stall_left == 0);
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= (stall_left == 0);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   initial begin
      cfg_type setting;
      int      goal;
      int      phase;
      int      phase_len;
      int      pick;
      req_bus.valid           = 1'b0;
      req_bus.func            = FUNC_TICK;
      req_bus.target_fraction = '0;
      csr_wr_en               = 1'b0;
      csr_index               = REG_STEP_SIZE;
      csr_wdata               = '0;
      reset                   = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // per-LED ramp up past full, hold, then down; clip on both ends of the hue map
      setting = '{step_size: 16'd7, leds_per_seg: 11'd0, unit_count: 11'd8,
                  start_hue: 16'd1000, end_hue: 16'd9000, max_bright: 8'd4,
                  clip_lower: 11'd1, clip_upper: 11'd2};
      load_config(setting);
      send_request(FUNC_SET_TARGET, 16'hFFFF);
      repeat (5) send_request(FUNC_TICK, 16'h0000);
      send_request(FUNC_TICK, 16'hFFFF);              // positions equal, silent
      send_request(FUNC_SET_TARGET, 16'(FULL_FRACTION / 2));
      send_request(FUNC_TICK, 16'h0000);
      send_request(FUNC_CLEAR, 16'hFFFF);
      send_request(FUNC_UNUSED, 16'h5A5A);
      wait_drained();

      // segmented: arriving in the target segment snaps the target, falling hue
      setting = '{step_size: 16'd4, leds_per_seg: 11'd3, unit_count: 11'd10,
                  start_hue: 16'd50000, end_hue: 16'd100, max_bright: 8'd4,
                  clip_lower: 11'd0, clip_upper: 11'd0};
      load_config(setting);
      send_request(FUNC_SET_TARGET, 16'd13107);
      repeat (3) send_request(FUNC_TICK, 16'h0000);
      send_request(FUNC_SET_TARGET, 16'h0000);
      send_request(FUNC_TICK, 16'h0000);
      wait_drained();

      // widest bar, unit count beyond the limit, largest step up to full
      setting = '{step_size: 16'hFFFF, leds_per_seg: 11'd1024, unit_count: 11'd2047,
                  start_hue: 16'd0, end_hue: 16'hFFFF, max_bright: 8'd255,
                  clip_lower: 11'd1024, clip_upper: 11'd1024};
      load_config(setting);
      send_request(FUNC_SET_TARGET, 16'(FULL_FRACTION));
      repeat (4) send_request(FUNC_TICK, 16'h0000);
      wait_drained();

      // first step down from full: guard write above lands past the LED index range
      setting.step_size = 16'd100;
      load_config(setting);
      send_request(FUNC_SET_TARGET, 16'h0000);
      send_request(FUNC_TICK, 16'h0000);
      wait_drained();

      // zero brightness reads as one; current far above the new top gets clamped
      setting = '{step_size: 16'd3, leds_per_seg: 11'd0, unit_count: 11'd10,
                  start_hue: 16'd20000, end_hue: 16'd40000, max_bright: 8'd0,
                  clip_lower: 11'd0, clip_upper: 11'd0};
      load_config(setting);
      send_request(FUNC_SET_TARGET, 16'h0000);
      repeat (2) send_request(FUNC_TICK, 16'h0000);

      goal  = sent_items + RANDOM_ITEMS;
      phase = 0;
      while (sent_items < goal) begin
         wait_drained();
         setting = random_config();
         load_config(setting);
         req_gap_mode   = idle_mode_t'($urandom_range(0, 2));
         rsp_stall_mode = idle_mode_t'($urandom_range(0, 2));
         if (phase % 4 == 1) holds_asked <= holds_asked + 1;
         phase_len = $urandom_range(30, 70);
         repeat (phase_len) begin
            pick = $urandom_range(0, 99);
            if (pick < 18)
               send_request(FUNC_SET_TARGET, ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                                             16'($urandom_range(0, FULL_FRACTION)));
            else if (pick < 21)
               send_request(FUNC_CLEAR, 16'($urandom));
            else if (pick < 23)
               send_request(FUNC_UNUSED, 16'($urandom));
            else if (pick == 23)
               wait_drained();
            else
               send_request(FUNC_TICK, 16'($urandom));
         end
         phase++;
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lbfr_pkg.sv
rtl/lbfr_if.sv
rtl/lbfr_csr.sv
rtl/lbfr_div.sv
rtl/led_bar_fill_ramp_top.sv
tb/sv/lbfr_ramp_checker.sv
tb/sv/tb.sv
